@@ sv/byte_stuffed_frame_ring_buffer_assert.svh @@
// Assertion helpers shared by the framer modules.
`ifndef BYTE_STUFFED_FRAME_RING_BUFFER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BSFRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsfrb: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BSFRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsfrb: next-cycle check failed");

`endif

@@ sv/bsfrb_pkg.sv @@
`default_nettype none

package bsfrb_pkg;

   localparam int unsigned STAGE_DEPTH = 256;
   localparam int unsigned STAGE_AW    = 8;
   localparam int unsigned STAGE_LEN_W = 8;
   localparam int unsigned FLEN_W      = 8;
   localparam int unsigned HDR_LEN     = 6;
   localparam int unsigned HDR_CNT_W   = 3;
   localparam int unsigned ADDR_W      = 10;
   localparam int unsigned POS_OUT_W   = 10;

   localparam logic [7:0] ESC_BYTE   = 8'd73;
   localparam logic [7:0] START_BYTE = 8'd74;

   typedef enum logic [1:0] {
      REQ_PAYLOAD = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_READ    = 2'd2,
      REQ_NOP     = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type        req_type;
      logic [7:0]          data_byte;
      logic                has_byte;
      logic                last_byte;
      logic [7:0]          pkt_type;
      logic [31:0]         timestamp;
      logic [ADDR_W-1:0]   read_addr;
   } req_payload_type;

   typedef struct packed {
      logic                 status;
      logic                 send_valid;
      logic [POS_OUT_W-1:0] send_start;
      logic [POS_OUT_W-1:0] run_len;
      logic [7:0]           read_data;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUT_ESC,
      ST_PUT_BYTE,
      ST_STATUS,
      ST_WRAP,
      ST_HDR,
      ST_COPY,
      ST_TICK,
      ST_RD_REDUCE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                put;
      logic [7:0]          put_byte;
      logic                clear;
      logic                rd_en;
      logic [STAGE_AW-1:0] rd_addr;
   } stage_cmd_type;

   typedef struct packed {
      logic              begin_frame;
      logic [FLEN_W-1:0] frame_len;
      logic              put;
      logic [7:0]        put_byte;
      logic              tick;
      logic              rd_en;
   } ring_cmd_type;

endpackage

`default_nettype wire

@@ sv/bsfrb_req_if.sv @@
`default_nettype none

interface bsfrb_req_if;
   logic                       valid;
   logic                       ready;
   bsfrb_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/bsfrb_rsp_if.sv @@
`default_nettype none

interface bsfrb_rsp_if;
   logic                       valid;
   logic                       ready;
   bsfrb_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/byte_stuffed_frame_ring_buffer.sv @@
// Byte-stuffing framer feeding a circular transmit ring.
// req_chan carries one request per transfer: a payload byte (stuffed into the
// stage store, escape before 73 or 74; last_byte commits, or if too long drops, the
// frame), a send tick (returns a send descriptor) or a ring read (returns the byte stored).
// rsp_chan returns exactly one result per request, in request order.
// A frame commit writes start byte, type, 4 timestamp bytes and the staged
// bytes into the ring, one byte a cycle through the ring write port.
// Toward the output register, an item without a byte passes the status state;
// a plain byte passes a byte write first, an escaped one an escape write and a
// byte write; a commit adds a wrap check, six header writes and the copy
// pipeline. A tick passes the tick state; a read folds RING_DEPTH off the
// address until it is below RING_DEPTH. The sequencer works on one request
// at a time and can take the next in the cycle after the result is loaded.
// Reset clears stage length, too-long flag, ring positions and the wrap flag;
// memory contents are not cleared and no clearing pass runs.
// A result waits in the output register while rsp_chan stalls; the next
// request is still taken and worked on, and holds in the response state
// until the register frees.
`default_nettype none

`include "byte_stuffed_frame_ring_buffer_assert.svh"

module byte_stuffed_frame_ring_buffer #(
   parameter int unsigned RING_DEPTH = 1024,
   parameter int unsigned MAX_FRAME  = 255
) (
   input wire logic   clock,
   input wire logic   reset,
   bsfrb_req_if.sink  req_chan,
   bsfrb_rsp_if.source rsp_chan
);

   localparam int unsigned RW    = $clog2(RING_DEPTH);
   localparam int unsigned CMP_W = ((RW > bsfrb_pkg::ADDR_W) ? RW : bsfrb_pkg::ADDR_W) + 1;

   bsfrb_pkg::state_type        state_ff, state_in;
   bsfrb_pkg::req_payload_type  req_ff, req_in;
   bsfrb_pkg::rsp_payload_type  res_ff, res_in;
   bsfrb_pkg::rsp_payload_type  rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bsfrb_pkg::HDR_CNT_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [bsfrb_pkg::STAGE_LEN_W-1:0] copy_idx_ff, copy_idx_in;
   logic                        copy_wr_ff, copy_wr_in;
   logic [bsfrb_pkg::ADDR_W-1:0] addr_ff, addr_in;

   bsfrb_pkg::stage_cmd_type    stage_cmd;
   bsfrb_pkg::ring_cmd_type     ring_cmd;
   logic [7:0]                  stage_rd_data;
   logic [bsfrb_pkg::STAGE_LEN_W-1:0] stage_len;
   logic                        stage_too_long;
   logic [RW-1:0]               ring_rd_addr;
   logic [7:0]                  ring_rd_data;
   logic                        send_valid;
   logic [RW-1:0]               send_start;
   logic [RW-1:0]               run_len;
   logic                        accept;
   logic                        slot_free;
   logic                        special_byte;
   logic [7:0]                  hdr_byte;

   assign accept       = req_chan.valid && req_chan.ready;
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;
   assign special_byte = (req_chan.payload.data_byte == bsfrb_pkg::ESC_BYTE) ||
                         (req_chan.payload.data_byte == bsfrb_pkg::START_BYTE);

   assign req_chan.ready   = (state_ff == bsfrb_pkg::ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
   assign ring_rd_addr     = RW'(addr_ff);

   // Header byte for the current header slot: start, type, timestamp little-endian.
   always_comb begin
      case (hdr_cnt_ff)
         3'd0:    hdr_byte = bsfrb_pkg::START_BYTE;
         3'd1:    hdr_byte = req_ff.pkt_type;
         3'd2:    hdr_byte = req_ff.timestamp[7:0];
         3'd3:    hdr_byte = req_ff.timestamp[15:8];
         3'd4:    hdr_byte = req_ff.timestamp[23:16];
         3'd5:    hdr_byte = req_ff.timestamp[31:24];
         default: hdr_byte = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      hdr_cnt_in   = hdr_cnt_ff;
      copy_idx_in  = copy_idx_ff;
      copy_wr_in   = 1'b0;
      addr_in      = addr_ff;
      stage_cmd    = '0;
      ring_cmd     = '0;

      case (state_ff)
         bsfrb_pkg::ST_IDLE: begin
            if (accept) begin
               req_in  = req_chan.payload;
               res_in  = '0;
               addr_in = req_chan.payload.read_addr;
               case (req_chan.payload.req_type)
                  bsfrb_pkg::REQ_PAYLOAD: begin
                     if (!req_chan.payload.has_byte) begin
                        state_in = bsfrb_pkg::ST_STATUS;
                     end else if (special_byte) begin
                        state_in = bsfrb_pkg::ST_PUT_ESC;
                     end else begin
                        state_in = bsfrb_pkg::ST_PUT_BYTE;
                     end
                  end
                  bsfrb_pkg::REQ_TICK: state_in = bsfrb_pkg::ST_TICK;
                  bsfrb_pkg::REQ_READ: state_in = bsfrb_pkg::ST_RD_REDUCE;
                  default:             state_in = bsfrb_pkg::ST_RESP;
               endcase
            end
         end

         bsfrb_pkg::ST_PUT_ESC: begin
            stage_cmd.put      = 1'b1;
            stage_cmd.put_byte = bsfrb_pkg::ESC_BYTE;
            state_in           = bsfrb_pkg::ST_PUT_BYTE;
         end

         bsfrb_pkg::ST_PUT_BYTE: begin
            stage_cmd.put      = 1'b1;
            stage_cmd.put_byte = req_ff.data_byte;
            state_in           = bsfrb_pkg::ST_STATUS;
         end

         bsfrb_pkg::ST_STATUS: begin
            // Report the too-long flag; on the last byte either drop or commit.
            res_in.status = stage_too_long;
            if (!req_ff.last_byte) begin
               state_in = bsfrb_pkg::ST_RESP;
            end else if (stage_too_long) begin
               stage_cmd.clear = 1'b1;
               state_in        = bsfrb_pkg::ST_RESP;
            end else begin
               state_in = bsfrb_pkg::ST_WRAP;
            end
         end

         bsfrb_pkg::ST_WRAP: begin
            ring_cmd.begin_frame = 1'b1;
            ring_cmd.frame_len   = bsfrb_pkg::FLEN_W'(stage_len) +
                                   bsfrb_pkg::FLEN_W'(bsfrb_pkg::HDR_LEN);
            hdr_cnt_in           = '0;
            state_in             = bsfrb_pkg::ST_HDR;
         end

         bsfrb_pkg::ST_HDR: begin
            ring_cmd.put      = 1'b1;
            ring_cmd.put_byte = hdr_byte;
            hdr_cnt_in        = hdr_cnt_ff + 1'b1;
            if (hdr_cnt_ff == bsfrb_pkg::HDR_CNT_W'(bsfrb_pkg::HDR_LEN - 1)) begin
               copy_idx_in = '0;
               state_in    = bsfrb_pkg::ST_COPY;
            end
         end

         bsfrb_pkg::ST_COPY: begin
            // Read the stage in the cycle before its ring write.
            if (copy_wr_ff) begin
               ring_cmd.put      = 1'b1;
               ring_cmd.put_byte = stage_rd_data;
            end
            if (copy_idx_ff < stage_len) begin
               stage_cmd.rd_en   = 1'b1;
               stage_cmd.rd_addr = bsfrb_pkg::STAGE_AW'(copy_idx_ff);
               copy_idx_in       = copy_idx_ff + 1'b1;
               copy_wr_in        = 1'b1;
            end else if (!copy_wr_ff) begin
               stage_cmd.clear = 1'b1;
               state_in        = bsfrb_pkg::ST_RESP;
            end
         end

         bsfrb_pkg::ST_TICK: begin
            ring_cmd.tick     = 1'b1;
            res_in.send_valid = send_valid;
            res_in.send_start = bsfrb_pkg::POS_OUT_W'(send_start);
            res_in.run_len    = bsfrb_pkg::POS_OUT_W'(run_len);
            state_in          = bsfrb_pkg::ST_RESP;
         end

         bsfrb_pkg::ST_RD_REDUCE: begin
            // Fold the address into the ring one depth at a time.
            if (CMP_W'(addr_ff) >= CMP_W'(RING_DEPTH)) begin
               addr_in = addr_ff - bsfrb_pkg::ADDR_W'(RING_DEPTH);
            end else begin
               ring_cmd.rd_en = 1'b1;
               state_in       = bsfrb_pkg::ST_RESP;
            end
         end

         bsfrb_pkg::ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               if (req_ff.req_type == bsfrb_pkg::REQ_READ) begin
                  rsp_in.read_data = ring_rd_data;
               end
               state_in = bsfrb_pkg::ST_IDLE;
            end
         end

         default: state_in = bsfrb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsfrb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         copy_wr_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         copy_wr_ff   <= copy_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      hdr_cnt_ff  <= hdr_cnt_in;
      copy_idx_ff <= copy_idx_in;
      addr_ff     <= addr_in;
   end

   bsfrb_stage #(
      .MAX_FRAME (MAX_FRAME)
   ) u_stage (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stage_cmd),
      .rd_data   (stage_rd_data),
      .stage_len (stage_len),
      .too_long  (stage_too_long)
   );

   bsfrb_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ring_cmd),
      .rd_addr    (ring_rd_addr),
      .rd_data    (ring_rd_data),
      .send_valid (send_valid),
      .send_start (send_start),
      .run_len    (run_len)
   );

   `BSFRB_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept,
      state_ff != bsfrb_pkg::ST_IDLE)
   `BSFRB_ASSERT_NOW(a_copy_bound, clock, reset, state_ff == bsfrb_pkg::ST_COPY,
      copy_idx_ff <= stage_len)
   `BSFRB_ASSERT_NEXT(a_resp_waits, clock, reset,
      state_ff == bsfrb_pkg::ST_RESP && rsp_valid_ff && !rsp_chan.ready,
      state_ff == bsfrb_pkg::ST_RESP && rsp_valid_ff)

endmodule

`default_nettype wire

@@ sv/bsfrb_stage.sv @@
`default_nettype none

`include "byte_stuffed_frame_ring_buffer_assert.svh"

module bsfrb_stage #(
   parameter int unsigned MAX_FRAME = 255
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bsfrb_pkg::stage_cmd_type            cmd,
   output logic [7:0]                               rd_data,
   output logic [bsfrb_pkg::STAGE_LEN_W-1:0]        stage_len,
   output logic                                     too_long
);

   // Largest stage length that still leaves room for the header.
   localparam logic [bsfrb_pkg::STAGE_LEN_W-1:0] LIMIT =
      bsfrb_pkg::STAGE_LEN_W'(MAX_FRAME - bsfrb_pkg::HDR_LEN);

   logic [7:0]                        stage_mem [bsfrb_pkg::STAGE_DEPTH];
   logic [7:0]                        rd_data_ff;
   logic [bsfrb_pkg::STAGE_LEN_W-1:0] stage_len_ff, stage_len_in;
   logic                              too_long_ff, too_long_in;
   logic                              store_ok;

   assign store_ok = cmd.put && !too_long_ff && (stage_len_ff < LIMIT);

   always_comb begin
      stage_len_in = stage_len_ff;
      too_long_in  = too_long_ff;
      if (cmd.clear) begin
         stage_len_in = '0;
         too_long_in  = 1'b0;
      end else if (cmd.put && !too_long_ff) begin
         if (store_ok) begin
            stage_len_in = stage_len_ff + 1'b1;
         end else begin
            too_long_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_len_ff <= '0;
         too_long_ff  <= 1'b0;
      end else begin
         stage_len_ff <= stage_len_in;
         too_long_ff  <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_ok && !cmd.clear) begin
         stage_mem[stage_len_ff] <= cmd.put_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= stage_mem[cmd.rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign stage_len = stage_len_ff;
   assign too_long  = too_long_ff;

   `BSFRB_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, stage_len_ff <= LIMIT)
   `BSFRB_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear,
      stage_len_ff == '0 && !too_long_ff)
   `BSFRB_ASSERT_NEXT(a_full_holds, clock, reset, too_long_ff && cmd.put && !cmd.clear,
      $stable(stage_len_ff) && too_long_ff)

endmodule

`default_nettype wire

@@ sv/bsfrb_ring.sv @@
`default_nettype none

`include "byte_stuffed_frame_ring_buffer_assert.svh"

module bsfrb_ring #(
   parameter int unsigned RING_DEPTH = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bsfrb_pkg::ring_cmd_type         cmd,
   input  wire logic [$clog2(RING_DEPTH)-1:0]   rd_addr,
   output logic [7:0]                           rd_data,
   output logic                                 send_valid,
   output logic [$clog2(RING_DEPTH)-1:0]        send_start,
   output logic [$clog2(RING_DEPTH)-1:0]        run_len
);

   localparam int unsigned RW    = $clog2(RING_DEPTH);
   localparam int unsigned SUM_W = ((RW > bsfrb_pkg::FLEN_W) ? RW : bsfrb_pkg::FLEN_W) + 1;
   localparam logic [RW-1:0] TOP_POS = RW'(RING_DEPTH - 1);

   logic [7:0]    ring_mem [RING_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [RW-1:0] write_pos_ff, write_pos_in;
   logic [RW-1:0] drain_pos_ff, drain_pos_in;
   logic [RW-1:0] wrap_end_ff, wrap_end_in;
   logic          wrapped_ff, wrapped_in;
   logic [RW-1:0] run_end;
   logic          run_valid;
   logic          frame_wraps;

   // Run available to a tick: up to the noted end after a wrap, else to the write position.
   assign run_end   = wrapped_ff ? wrap_end_ff : write_pos_ff;
   assign run_valid = drain_pos_ff < run_end;

   assign frame_wraps = (SUM_W'(write_pos_ff) + SUM_W'(cmd.frame_len)) >= SUM_W'(RING_DEPTH);

   always_comb begin
      write_pos_in = write_pos_ff;
      drain_pos_in = drain_pos_ff;
      wrap_end_in  = wrap_end_ff;
      wrapped_in   = wrapped_ff;
      if (cmd.begin_frame && frame_wraps) begin
         wrap_end_in  = write_pos_ff;
         write_pos_in = '0;
         wrapped_in   = 1'b1;
      end
      if (cmd.put) begin
         write_pos_in = (write_pos_ff == TOP_POS) ? '0 : write_pos_ff + 1'b1;
      end
      if (cmd.tick) begin
         if (wrapped_ff) begin
            drain_pos_in = '0;
            wrapped_in   = 1'b0;
         end else if (run_valid) begin
            drain_pos_in = write_pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         drain_pos_ff <= '0;
         wrap_end_ff  <= '0;
         wrapped_ff   <= 1'b0;
      end else begin
         write_pos_ff <= write_pos_in;
         drain_pos_ff <= drain_pos_in;
         wrap_end_ff  <= wrap_end_in;
         wrapped_ff   <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         ring_mem[write_pos_ff] <= cmd.put_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign send_valid = run_valid;
   assign send_start = run_valid ? drain_pos_ff : '0;
   assign run_len    = run_valid ? (run_end - drain_pos_ff) : '0;

   `BSFRB_ASSERT_NOW(a_wp_range, clock, reset, 1'b1,
      write_pos_ff <= TOP_POS && wrap_end_ff <= TOP_POS)
   `BSFRB_ASSERT_NEXT(a_tick_unwraps, clock, reset, cmd.tick && wrapped_ff,
      !wrapped_ff && drain_pos_ff == '0)
   `BSFRB_ASSERT_NOW(a_run_nonempty, clock, reset, run_valid, run_len != '0)

endmodule

`default_nettype wire
